[hdl/iphc_pkg.sv]
// ----------------------------------------------------------------------------
// iphc_pkg: shared types and constants for the IPv6 pseudo-header checksum
// Byte beat and result structures, header byte offsets, family and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package iphc_pkg;

	// One packet byte with its framing marks
	typedef struct packed {
		logic [7:0] data_byte;
		logic       segment_end;
		logic       packet_end;
	} beat_t;

	// One checksum result
	typedef struct packed {
		logic [15:0] checksum;
		logic [1:0]  status;
	} result_t;

	// Header byte offsets of the pseudo-header fields
	localparam logic [5:0] OFS_PLEN_HI  = 6'd4;
	localparam logic [5:0] OFS_PLEN_LO  = 6'd5;
	localparam logic [5:0] OFS_NEXT_HDR = 6'd6;
	localparam logic [5:0] OFS_SRC      = 6'd8;
	localparam logic [5:0] HDR_LIMIT    = 6'd40;

	// Family mode codes
	localparam logic [1:0] FAM_IPV6 = 2'd0;
	localparam logic [1:0] FAM_IPV4 = 2'd1;

	// Status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_IPV4 = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

endpackage

`default_nettype wire

[hdl/iphc_accum.sv]
// ----------------------------------------------------------------------------
// iphc_accum: per-packet ones' complement accumulator
// Picks the pseudo-header words out of the first segment, pairs later bytes
// into big-endian words, adds with end-around carry, forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module iphc_accum (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire iphc_pkg::beat_t  beat,
	input  wire logic [1:0]       family_mode,
	output iphc_pkg::result_t     result
);
	import iphc_pkg::*;

	logic [15:0] sum_q;
	logic [7:0]  held_q;
	logic        odd_q;
	logic [5:0]  hdr_cnt_q;
	logic        first_q;

	logic [15:0] sum_n;
	logic [7:0]  held_n;
	logic        odd_n;
	logic [5:0]  hdr_cnt_n;
	logic        first_n;

	logic        add_en;
	logic [15:0] word;
	logic [16:0] raw_sum;
	logic [15:0] sum_add;
	logic        send;
	logic [7:0]  b;

	assign b    = beat.data_byte;
	assign send = beat.segment_end | beat.packet_end;

	// Select the word to add and the next packet state
	always_comb begin
		add_en    = 1'b0;
		word      = 16'h0000;
		held_n    = held_q;
		odd_n     = odd_q;
		hdr_cnt_n = hdr_cnt_q;
		first_n   = first_q;
		if (first_q) begin
			if (hdr_cnt_q == OFS_PLEN_HI) begin
				add_en = 1'b1;
				word   = {b, 8'h00};
			end else if (hdr_cnt_q == OFS_PLEN_LO || hdr_cnt_q == OFS_NEXT_HDR) begin
				add_en = 1'b1;
				word   = {8'h00, b};
			end else if (hdr_cnt_q >= OFS_SRC && hdr_cnt_q < HDR_LIMIT) begin
				add_en = 1'b1;
				word   = hdr_cnt_q[0] ? {8'h00, b} : {b, 8'h00};
			end
			if (hdr_cnt_q < HDR_LIMIT) begin
				hdr_cnt_n = hdr_cnt_q + 6'd1;
			end
			if (send) begin
				first_n = 1'b0;
				odd_n   = 1'b0;
				held_n  = 8'h00;
			end
		end else begin
			if (odd_q) begin
				add_en = 1'b1;
				word   = {held_q, b};
				odd_n  = 1'b0;
			end else if (send) begin
				add_en = 1'b1;
				word   = {b, 8'h00};
			end else begin
				held_n = b;
				odd_n  = 1'b1;
			end
			if (send) begin
				odd_n = 1'b0;
			end
		end
	end

	// Add with end-around carry
	assign raw_sum = {1'b0, sum_q} + {1'b0, word};
	assign sum_add = raw_sum[15:0] + {15'd0, raw_sum[16]};
	assign sum_n   = add_en ? sum_add : sum_q;

	// Form the result from the updated sum in IPv6 mode; other modes give a zero checksum
	always_comb begin
		case (family_mode)
			FAM_IPV6: begin
				result.checksum = ~sum_n;
				result.status   = STAT_OK;
			end
			FAM_IPV4: begin
				result.checksum = 16'h0000;
				result.status   = STAT_IPV4;
			end
			default: begin
				result.checksum = 16'h0000;
				result.status   = STAT_BAD;
			end
		endcase
	end

	// Advance the packet state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= 16'h0000;
			held_q    <= 8'h00;
			odd_q     <= 1'b0;
			hdr_cnt_q <= 6'd0;
			first_q   <= 1'b1;
		end else if (step) begin
			if (beat.packet_end) begin
				sum_q     <= 16'h0000;
				held_q    <= 8'h00;
				odd_q     <= 1'b0;
				hdr_cnt_q <= 6'd0;
				first_q   <= 1'b1;
			end else begin
				sum_q     <= sum_n;
				held_q    <= held_n;
				odd_q     <= odd_n;
				hdr_cnt_q <= hdr_cnt_n;
				first_q   <= first_n;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/iphc_out_reg.sv]
// ----------------------------------------------------------------------------
// iphc_out_reg: result register
// Holds one checksum result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module iphc_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire iphc_pkg::result_t  result_in,
	input  wire logic               out_stall,
	output logic                    out_free,
	output logic                    out_valid,
	output iphc_pkg::result_t       result_out
);
	import iphc_pkg::*;

	logic    valid_q;
	result_t result_q;

	// Room for a new result when empty or when the held one transfers now
	assign out_free   = !valid_q || !out_stall;
	assign out_valid  = valid_q;
	assign result_out = result_q;

	// Load a new result, drop the old one once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

endmodule

`default_nettype wire

[hdl/ipv6_pseudo_header_checksum_core.sv]
// ----------------------------------------------------------------------------
// ipv6_pseudo_header_checksum_core: streaming IPv6 pseudo-header checksum
// Input channel: one packet byte per transfer (in_valid/in_stall) with
// segment_end and packet_end marks; the first segment is the IPv6 header.
// Output channel: one checksum/status result per packet (out_valid/out_stall),
// presented after the transfer that carries packet_end.
// Configuration: family_mode via cfg_wr_en/cfg_wr_data; the user writes it only while
// idle (not enforced here); 0 IPv6, 1 IPv4 (status 1, checksum 0), else status 2.
// Timing: a byte is registered on its transfer and summed as it leaves the input
// register; a packet's result is loaded into the result register as its packet_end
// byte leaves the input register, and out_valid then presents it.
// Throughput: one byte per cycle while the input is not stalled; the end-around-carry
// adder in the accumulator is combinational.
// Reset: clears the packet state, family_mode to IPv6 and both valid flags.
// Stall: a stalled result holds; the input register keeps taking bytes and
// stalls only when a packet_end byte waits for the result register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_pseudo_header_checksum_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        segment_end,
	input  wire logic        packet_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      checksum,
	output logic [1:0]       status
);
	import iphc_pkg::*;

	logic [1:0] family_mode_q;
	logic       valid_s1;
	beat_t      beat_s1;
	logic       adv_s1;
	logic       out_free;
	logic       accept;
	result_t    acc_result;
	result_t    out_result;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			family_mode_q <= FAM_IPV6;
		end else if (cfg_wr_en) begin
			family_mode_q <= cfg_wr_data;
		end
	end

	// Input register handshake
	assign adv_s1   = valid_s1 && (!beat_s1.packet_end || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= '{data_byte: data_byte, segment_end: segment_end,
				packet_end: packet_end};
		end
	end

	// Accumulate the registered byte
	iphc_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.beat        (beat_s1),
		.family_mode (family_mode_q),
		.result      (acc_result)
	);

	// Hold the result for the receiver
	iphc_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv_s1 && beat_s1.packet_end),
		.result_in  (acc_result),
		.out_stall  (out_stall),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.result_out (out_result)
	);

	assign checksum = out_result.checksum;
	assign status   = out_result.status;

	// A stall on the input side only comes from a packet end waiting on the result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && beat_s1.packet_end && out_valid && out_stall))
		else $error("input stalled without a blocked packet end");

	// A finished packet always shows a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && beat_s1.packet_end) |=> out_valid)
		else $error("packet end did not produce a result");

	// Non-ok status carries a zero checksum
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_OK) |-> (checksum == 16'h0000))
		else $error("error status with nonzero checksum");

endmodule

`default_nettype wire
